// File: rtl/epir_pkg.sv
// epir_pkg: shared constants, types and helper functions for the ellipse raster unit
`default_nettype none
package epir_pkg;

    localparam int RADIUS_INT_BITS = 12;
    localparam int FRAC_BITS       = 30;
    localparam int RAD_FRAC        = 8;
    localparam int RAD_W           = RADIUS_INT_BITS + RAD_FRAC;
    localparam int CTR_W           = 12;
    localparam int PT_W            = 14;
    localparam int COL_W           = 24;
    localparam int POS_W           = 48;
    localparam int CS_W            = FRAC_BITS + 2;
    localparam int T_W             = FRAC_BITS + 1;
    localparam int ALU_W           = 64;
    localparam int DIV_W           = RAD_W;
    localparam int IN_W            = ((2 * CTR_W + 2 * RAD_W + 7) / 8) * 8;
    localparam int OUT_W           = ((2 * PT_W + COL_W + 7) / 8) * 8;
    localparam int SERIES_TERMS    = 5;
    localparam int RECIP_SHIFT     = 8;
    localparam int RECIP_W         = FRAC_BITS + RECIP_SHIFT;
    localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_W;
    localparam logic [COL_W-1:0] COLOR_RESET = 24'hFF0000;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    typedef enum logic [0:0] {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    go;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic    done;
        logic    busy;
    } t_alu_rsp;

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIN
    } t_alu_state;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_DIV,
        S_T2_MUL,
        S_C_MUL,
        S_C_DIV,
        S_S_MUL,
        S_S_DIV,
        S_RXY,
        S_RYX,
        S_X_A,
        S_X_B,
        S_X_B2,
        S_Y_C,
        S_Y_D,
        S_Y_D2,
        S_ROUND,
        S_EMIT
    } t_seq_state;

    // reciprocals of the cosine divisor pairs, scaled by 2^RECIP_W and rounded up
    function automatic logic [RECIP_W-1:0] cos_recip(input logic [2:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            3'd1:    r = RECIP_W'((RECIP_ONE + 64'd1) / 64'd2);
            3'd2:    r = RECIP_W'((RECIP_ONE + 64'd11) / 64'd12);
            3'd3:    r = RECIP_W'((RECIP_ONE + 64'd29) / 64'd30);
            3'd4:    r = RECIP_W'((RECIP_ONE + 64'd55) / 64'd56);
            default: r = RECIP_W'((RECIP_ONE + 64'd89) / 64'd90);
        endcase
        return r;
    endfunction

    // reciprocals of the sine divisor pairs, scaled by 2^RECIP_W and rounded up
    function automatic logic [RECIP_W-1:0] sin_recip(input logic [2:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            3'd1:    r = RECIP_W'((RECIP_ONE + 64'd5) / 64'd6);
            3'd2:    r = RECIP_W'((RECIP_ONE + 64'd19) / 64'd20);
            3'd3:    r = RECIP_W'((RECIP_ONE + 64'd41) / 64'd42);
            3'd4:    r = RECIP_W'((RECIP_ONE + 64'd71) / 64'd72);
            default: r = RECIP_W'((RECIP_ONE + 64'd109) / 64'd110);
        endcase
        return r;
    endfunction

    // round half up then truncate toward zero, low pixel bits only
    function automatic logic [PT_W-1:0] round_pt(input logic [POS_W-1:0] v);
        logic [POS_W:0]           w;
        logic [POS_W-FRAC_BITS:0] q;
        w = {v[POS_W-1], v} + (POS_W+1)'(64'd1 << (FRAC_BITS - 1));
        q = w[POS_W:FRAC_BITS];
        if (w[POS_W] && (|w[FRAC_BITS-1:0])) begin
            q = q + 1'b1;
        end
        return q[PT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/epir_alu.sv
// epir_alu: shared multi-cycle signed fixed-point multiplier and unsigned divider
`default_nettype none
module epir_alu (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire epir_pkg::t_alu_req            i_req,
    input  wire [epir_pkg::ALU_W-1:0]          i_a,
    input  wire [epir_pkg::ALU_W-1:0]          i_b,
    output epir_pkg::t_alu_rsp                 o_rsp,
    output logic [epir_pkg::ALU_W-1:0]         o_res
);

    localparam int W      = epir_pkg::ALU_W;
    localparam int DIGIT  = 8;
    localparam int MSTEPS = W / DIGIT;

    epir_pkg::t_alu_state r_state, n_state;
    logic [5:0]           r_cnt, n_cnt;
    logic                 r_neg, n_neg;
    logic [W-1:0]         r_ma, n_ma;
    logic [W-1:0]         r_hi, n_hi;
    logic [W-1:0]         r_lo, n_lo;
    logic [epir_pkg::DIV_W-1:0] r_div, n_div;
    logic                 r_is_div, n_is_div;
    logic [W-1:0]         r_res, n_res;
    logic                 r_done, n_done;

    logic [W+DIGIT-1:0]   mul_sum;
    logic [epir_pkg::DIV_W:0] div_rem;
    logic                 div_ge;
    logic [2*W-1:0]       prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= epir_pkg::A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cnt    <= n_cnt;
        r_neg    <= n_neg;
        r_ma     <= n_ma;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_div    <= n_div;
        r_is_div <= n_is_div;
        r_res    <= n_res;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_ma     = r_ma;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_div    = r_div;
        n_is_div = r_is_div;
        n_res    = r_res;
        n_done   = 1'b0;

        mul_sum = {{DIGIT{1'b0}}, r_hi} + r_ma * r_lo[DIGIT-1:0];
        div_rem = {r_hi[epir_pkg::DIV_W-1:0], r_lo[W-1]};
        div_ge  = (div_rem >= {1'b0, r_div});
        prod    = {r_hi, r_lo};
        if (r_neg) begin
            prod = ~prod + 1'b1;
        end

        unique case (r_state)
            epir_pkg::A_IDLE: begin
                if (i_req.go) begin
                    n_hi = '0;
                    if (i_req.op == epir_pkg::ALU_DIV) begin
                        n_lo     = i_a;
                        n_div    = i_b[epir_pkg::DIV_W-1:0];
                        n_neg    = 1'b0;
                        n_is_div = 1'b1;
                        n_cnt    = 6'(W - 1);
                        n_state  = epir_pkg::A_DIV;
                    end else begin
                        n_ma     = i_a[W-1] ? (~i_a + 1'b1) : i_a;
                        n_lo     = i_b[W-1] ? (~i_b + 1'b1) : i_b;
                        n_neg    = i_a[W-1] ^ i_b[W-1];
                        n_is_div = 1'b0;
                        n_cnt    = 6'(MSTEPS - 1);
                        n_state  = epir_pkg::A_MUL;
                    end
                end
            end
            epir_pkg::A_MUL: begin
                n_hi  = mul_sum[W+DIGIT-1:DIGIT];
                n_lo  = {mul_sum[DIGIT-1:0], r_lo[W-1:DIGIT]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = epir_pkg::A_FIN;
                end
            end
            epir_pkg::A_DIV: begin
                n_hi  = W'(div_ge ? (div_rem - {1'b0, r_div}) : div_rem);
                n_lo  = {r_lo[W-2:0], div_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = epir_pkg::A_FIN;
                end
            end
            epir_pkg::A_FIN: begin
                n_res   = r_is_div ? r_lo : prod[W+epir_pkg::FRAC_BITS-1:epir_pkg::FRAC_BITS];
                n_done  = 1'b1;
                n_state = epir_pkg::A_IDLE;
            end
            default: begin
                n_state = epir_pkg::A_IDLE;
            end
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = (r_state != epir_pkg::A_IDLE);
    assign o_res      = r_res;

endmodule
`default_nettype wire

// File: rtl/ellipse_polar_iterative_raster_unit.sv
// ellipse_polar_iterative_raster_unit: top level, sequencer around the shared arithmetic unit
//
//  channel | dir | words
//  s_axis  | in  | tuser: req_type; tdata: center_x, center_y, radius_x, radius_y
//  m_axis  | out | tuser: status, ellipse_done; tlast: last_of_step
//          |     | tdata: point_x, point_y, pixel_color
//  cfg     | in  | i_cfg_we, i_cfg_wdata: draw_color
//
//  multiplies and divides all go through the one shared unit
//  a step word runs six multiplies, a rounding step and four output words
//  a start word runs three divides, 21 multiplies and four output words
//  a rejected start gives one status word, a step word while not drawing gives nothing
//  s_axis_tready is high only when idle, an m_axis stall holds the block on its output word
//  reset is synchronous and active low
`default_nettype none
module ellipse_polar_iterative_raster_unit (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire [epir_pkg::IN_W-1:0]          s_axis_tdata,  // center_x, center_y, radius_x, radius_y
    input  wire                               s_axis_tuser,  // req_type
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [epir_pkg::OUT_W-1:0]        m_axis_tdata,  // point_x, point_y, pixel_color
    output logic [1:0]                        m_axis_tuser,  // status, ellipse_done
    output logic                              m_axis_tlast,
    input  wire                               i_cfg_we,
    input  wire [epir_pkg::COL_W-1:0]         i_cfg_wdata
);

    localparam int FB  = epir_pkg::FRAC_BITS;
    localparam int W   = epir_pkg::ALU_W;
    localparam int RW  = epir_pkg::RAD_W;
    localparam int PW  = epir_pkg::PT_W;
    localparam int CW  = epir_pkg::CTR_W;
    localparam int SW  = epir_pkg::POS_W;
    localparam int CSW = epir_pkg::CS_W;
    localparam int TW  = epir_pkg::T_W;

    epir_pkg::t_seq_state r_state, n_state;
    logic               r_wait, n_wait;
    logic               r_active, n_active;
    logic               r_reject, n_reject;
    logic               r_done, n_done;
    logic [2:0]         r_k, n_k;
    logic [1:0]         r_idx, n_idx;
    logic [RW-1:0]      r_r1, n_r1;
    logic [RW-1:0]      r_r2, n_r2;
    logic [CW-1:0]      r_cx, n_cx;
    logic [CW-1:0]      r_cy, n_cy;
    logic [TW-1:0]      r_t, n_t;
    logic [TW-1:0]      r_t2, n_t2;
    logic [TW-1:0]      r_term, n_term;
    logic [CSW-1:0]     r_cos, n_cos;
    logic [CSW-1:0]     r_sin, n_sin;
    logic [SW-1:0]      r_rxy, n_rxy;
    logic [SW-1:0]      r_ryx, n_ryx;
    logic [SW-1:0]      r_pos_x, n_pos_x;
    logic [SW-1:0]      r_pos_y, n_pos_y;
    logic [SW-1:0]      r_nx, n_nx;
    logic [W-1:0]       r_tmp, n_tmp;
    logic [W-1:0]       r_tmp2, n_tmp2;
    logic [PW-1:0]      r_pa, n_pa;
    logic [PW-1:0]      r_pb, n_pb;
    logic [epir_pkg::COL_W-1:0] r_color;

    logic               r_m_valid, n_m_valid;
    logic [epir_pkg::OUT_W-1:0] r_m_data, n_m_data;
    logic [1:0]         r_m_user, n_m_user;
    logic               r_m_last, n_m_last;

    epir_pkg::t_alu_req alu_req;
    epir_pkg::t_alu_rsp alu_rsp;
    logic [W-1:0]       alu_a, alu_b, alu_res;
    logic               take;
    logic               in_acc;
    logic [RW-1:0]      rad_max;
    logic [TW-1:0]      quot;
    logic [SW-1:0]      ny;
    logic [PW-1:0]      cx14, cy14, px, py;

    epir_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_rsp   (alu_rsp),
        .o_res   (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= epir_pkg::S_IDLE;
            r_wait    <= 1'b0;
            r_active  <= 1'b0;
            r_m_valid <= 1'b0;
            r_color   <= epir_pkg::COLOR_RESET;
        end else begin
            r_state   <= n_state;
            r_wait    <= n_wait;
            r_active  <= n_active;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
        end
        r_reject <= n_reject;
        r_done   <= n_done;
        r_k      <= n_k;
        r_idx    <= n_idx;
        r_r1     <= n_r1;
        r_r2     <= n_r2;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_t      <= n_t;
        r_t2     <= n_t2;
        r_term   <= n_term;
        r_cos    <= n_cos;
        r_sin    <= n_sin;
        r_rxy    <= n_rxy;
        r_ryx    <= n_ryx;
        r_pos_x  <= n_pos_x;
        r_pos_y  <= n_pos_y;
        r_nx     <= n_nx;
        r_tmp    <= n_tmp;
        r_tmp2   <= n_tmp2;
        r_pa     <= n_pa;
        r_pb     <= n_pb;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
        r_m_last <= n_m_last;
    end

    assign s_axis_tready = (r_state == epir_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign take          = r_wait && alu_rsp.done;
    assign rad_max       = (r_r1 > r_r2) ? r_r1 : r_r2;
    assign quot          = alu_res[epir_pkg::RECIP_SHIFT +: TW];
    assign ny            = SW'(r_tmp + alu_res);
    assign cx14          = PW'(r_cx);
    assign cy14          = PW'(r_cy);
    assign px            = r_idx[1] ? (cx14 + r_pa) : (cx14 - r_pa);
    assign py            = r_idx[0] ? (cy14 - r_pb) : (cy14 + r_pb);

    always_comb begin
        n_state   = r_state;
        n_wait    = r_wait;
        n_active  = r_active;
        n_reject  = r_reject;
        n_done    = r_done;
        n_k       = r_k;
        n_idx     = r_idx;
        n_r1      = r_r1;
        n_r2      = r_r2;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_t       = r_t;
        n_t2      = r_t2;
        n_term    = r_term;
        n_cos     = r_cos;
        n_sin     = r_sin;
        n_rxy     = r_rxy;
        n_ryx     = r_ryx;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_nx      = r_nx;
        n_tmp     = r_tmp;
        n_tmp2    = r_tmp2;
        n_pa      = r_pa;
        n_pb      = r_pb;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_data  = r_m_data;
        n_m_user  = r_m_user;
        n_m_last  = r_m_last;
        alu_req.go = 1'b0;
        alu_req.op = epir_pkg::ALU_MUL;
        alu_a      = '0;
        alu_b      = '0;

        unique case (r_state)
            epir_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == epir_pkg::REQ_START) begin
                        n_active = 1'b0;
                        n_r1     = s_axis_tdata[2*CW +: RW];
                        n_r2     = s_axis_tdata[2*CW+RW +: RW];
                        if ((s_axis_tdata[2*CW+epir_pkg::RAD_FRAC +: epir_pkg::RADIUS_INT_BITS] == '0)
                            || (s_axis_tdata[2*CW+RW+epir_pkg::RAD_FRAC +: epir_pkg::RADIUS_INT_BITS]
                                == '0)) begin
                            n_reject = 1'b1;
                            n_idx    = '0;
                            n_state  = epir_pkg::S_EMIT;
                        end else begin
                            n_reject = 1'b0;
                            n_cx     = s_axis_tdata[CW-1:0];
                            n_cy     = s_axis_tdata[2*CW-1:CW];
                            n_state  = epir_pkg::S_T_DIV;
                        end
                    end else if (r_active) begin
                        n_reject = 1'b0;
                        n_state  = epir_pkg::S_X_A;
                    end
                end
            end
            epir_pkg::S_T_DIV: begin
                alu_req.op = epir_pkg::ALU_DIV;
                alu_a      = W'(64'd1 << FB);
                alu_b      = W'(rad_max[RW-1:epir_pkg::RAD_FRAC]);
                if (take) begin
                    n_t     = alu_res[TW-1:0];
                    n_state = epir_pkg::S_T2_MUL;
                end
            end
            epir_pkg::S_T2_MUL: begin
                alu_a = W'(r_t);
                alu_b = W'(r_t);
                if (take) begin
                    n_t2    = alu_res[TW-1:0];
                    n_term  = TW'(64'd1 << FB);
                    n_cos   = CSW'(64'd1 << FB);
                    n_k     = 3'd1;
                    n_state = epir_pkg::S_C_MUL;
                end
            end
            epir_pkg::S_C_MUL, epir_pkg::S_S_MUL: begin
                alu_a = W'(r_term);
                alu_b = W'(r_t2);
                if (take) begin
                    n_term  = alu_res[TW-1:0];
                    n_state = (r_state == epir_pkg::S_C_MUL) ? epir_pkg::S_C_DIV
                                                             : epir_pkg::S_S_DIV;
                end
            end
            epir_pkg::S_C_DIV: begin
                alu_a = W'(r_term);
                alu_b = W'(epir_pkg::cos_recip(r_k));
                if (take) begin
                    n_term = quot;
                    n_cos  = r_k[0] ? (r_cos - CSW'(quot)) : (r_cos + CSW'(quot));
                    if (r_k == 3'(epir_pkg::SERIES_TERMS)) begin
                        n_term  = r_t;
                        n_sin   = CSW'(r_t);
                        n_k     = 3'd1;
                        n_state = epir_pkg::S_S_MUL;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = epir_pkg::S_C_MUL;
                    end
                end
            end
            epir_pkg::S_S_DIV: begin
                alu_a = W'(r_term);
                alu_b = W'(epir_pkg::sin_recip(r_k));
                if (take) begin
                    n_term = quot;
                    n_sin  = r_k[0] ? (r_sin - CSW'(quot)) : (r_sin + CSW'(quot));
                    if (r_k == 3'(epir_pkg::SERIES_TERMS)) begin
                        n_state = epir_pkg::S_RXY;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = epir_pkg::S_S_MUL;
                    end
                end
            end
            epir_pkg::S_RXY: begin
                alu_req.op = epir_pkg::ALU_DIV;
                alu_a      = W'(r_r1) << FB;
                alu_b      = W'(r_r2);
                if (take) begin
                    n_rxy   = alu_res[SW-1:0];
                    n_state = epir_pkg::S_RYX;
                end
            end
            epir_pkg::S_RYX: begin
                alu_req.op = epir_pkg::ALU_DIV;
                alu_a      = W'(r_r2) << FB;
                alu_b      = W'(r_r1);
                if (take) begin
                    n_ryx    = alu_res[SW-1:0];
                    n_pos_x  = SW'(r_r1) << (FB - epir_pkg::RAD_FRAC);
                    n_pos_y  = '0;
                    n_active = 1'b1;
                    n_pa     = PW'(r_r1[RW-1:epir_pkg::RAD_FRAC]);
                    n_pb     = '0;
                    n_done   = 1'b0;
                    n_idx    = '0;
                    n_state  = epir_pkg::S_EMIT;
                end
            end
            epir_pkg::S_X_A: begin
                alu_a = {{(W-SW){r_pos_x[SW-1]}}, r_pos_x};
                alu_b = W'(r_cos);
                if (take) begin
                    n_tmp   = alu_res;
                    n_state = epir_pkg::S_X_B;
                end
            end
            epir_pkg::S_X_B: begin
                alu_a = W'(r_rxy);
                alu_b = {{(W-SW){r_pos_y[SW-1]}}, r_pos_y};
                if (take) begin
                    n_tmp2  = alu_res;
                    n_state = epir_pkg::S_X_B2;
                end
            end
            epir_pkg::S_X_B2: begin
                alu_a = r_tmp2;
                alu_b = W'(r_sin);
                if (take) begin
                    n_nx    = SW'(r_tmp - alu_res);
                    n_state = epir_pkg::S_Y_C;
                end
            end
            epir_pkg::S_Y_C: begin
                alu_a = {{(W-SW){r_pos_y[SW-1]}}, r_pos_y};
                alu_b = W'(r_cos);
                if (take) begin
                    n_tmp   = alu_res;
                    n_state = epir_pkg::S_Y_D;
                end
            end
            epir_pkg::S_Y_D: begin
                alu_a = W'(r_ryx);
                alu_b = {{(W-SW){r_pos_x[SW-1]}}, r_pos_x};
                if (take) begin
                    n_tmp2  = alu_res;
                    n_state = epir_pkg::S_Y_D2;
                end
            end
            epir_pkg::S_Y_D2: begin
                alu_a = r_tmp2;
                alu_b = W'(r_sin);
                if (take) begin
                    n_pos_x  = r_nx;
                    n_pos_y  = ny;
                    n_done   = r_nx[SW-1] || (r_nx == '0);
                    n_active = !(r_nx[SW-1] || (r_nx == '0));
                    n_state  = epir_pkg::S_ROUND;
                end
            end
            epir_pkg::S_ROUND: begin
                n_pa    = epir_pkg::round_pt(r_pos_x);
                n_pb    = epir_pkg::round_pt(r_pos_y);
                n_idx   = '0;
                n_state = epir_pkg::S_EMIT;
            end
            epir_pkg::S_EMIT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    if (r_reject) begin
                        n_m_data = epir_pkg::OUT_W'({r_color, {(2*PW){1'b0}}});
                        n_m_user = 2'b01;
                        n_m_last = 1'b1;
                        n_state  = epir_pkg::S_IDLE;
                    end else begin
                        n_m_data = epir_pkg::OUT_W'({r_color, py, px});
                        n_m_user = {r_done && (r_idx == 2'd3), 1'b0};
                        n_m_last = (r_idx == 2'd3);
                        n_idx    = r_idx + 1'b1;
                        if (r_idx == 2'd3) begin
                            n_state = epir_pkg::S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = epir_pkg::S_IDLE;
            end
        endcase

        // issue once per arithmetic state, then wait for the result
        if ((r_state != epir_pkg::S_IDLE) && (r_state != epir_pkg::S_ROUND)
            && (r_state != epir_pkg::S_EMIT)) begin
            if (!r_wait && !alu_rsp.busy) begin
                alu_req.go = 1'b1;
                n_wait     = 1'b1;
            end else if (take) begin
                n_wait = 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

endmodule
`default_nettype wire

// File: rtl/epir_checker.sv
// epir_checker: port-level assertions for the ellipse raster unit, bound to the top level
`default_nettype none
module epir_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            s_axis_tvalid,
    input wire                            s_axis_tready,
    input wire                            s_axis_tuser,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [epir_pkg::OUT_W-1:0]      m_axis_tdata,
    input wire [1:0]                      m_axis_tuser,
    input wire                            m_axis_tlast
);

    // stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed under stall");

    // rejected start is a single zero point
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tlast && !m_axis_tuser[1] && (m_axis_tdata[2*epir_pkg::PT_W-1:0] == '0))
        else $error("bad reject word");

    // end of ellipse only on the last word of a step
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("ellipse_done without tlast");

    // a start word keeps the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == epir_pkg::REQ_START)
            |=> !s_axis_tready)
        else $error("start word did not occupy the block");

    // nothing pending out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind ellipse_polar_iterative_raster_unit epir_checker u_epir_checker (.*);
`default_nettype wire

// File: verif/tb_top.sv
// testbench for the ellipse raster unit: directed and random draws against a built-in predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int PT_W           = epir_pkg::PT_W;
    localparam int COL_W          = epir_pkg::COL_W;
    localparam int IN_W           = epir_pkg::IN_W;
    localparam int OUT_W          = epir_pkg::OUT_W;
    localparam int CTR_W          = epir_pkg::CTR_W;
    localparam int RAD_W          = epir_pkg::RAD_W;
    localparam int RAD_FRAC       = epir_pkg::RAD_FRAC;
    localparam int FRAC_BITS      = epir_pkg::FRAC_BITS;

    typedef struct {
        logic [PT_W-1:0]  px;
        logic [PT_W-1:0]  py;
        logic [COL_W-1:0] col;
        logic             st;
        logic             last;
        logic             done;
    } t_point;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata = '0;
    logic               s_axis_tuser = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic [1:0]         m_axis_tuser;
    logic               m_axis_tlast;
    logic               i_cfg_we = 1'b0;
    logic [COL_W-1:0]   i_cfg_wdata = '0;

    ellipse_polar_iterative_raster_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [63:0]      ell_px, ell_py, ell_cos, ell_sin, ell_rxy, ell_ryx, ell_cx, ell_cy;
    logic             ell_active;
    logic [COL_W-1:0] ell_color;
    t_point           exp_points[$];
    int               err_count;
    int               words_sent;
    bit               no_idle;
    int               quiet_cycles;

    function automatic logic [63:0] umul_fx(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[FRAC_BITS+63:FRAC_BITS];
    endfunction

    function automatic logic [63:0] smul_fx(input logic [63:0] a, input logic [63:0] b);
        logic signed [127:0] p;
        p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        return p[FRAC_BITS+63:FRAC_BITS];
    endfunction

    function automatic logic [63:0] wrap_pos(input logic [63:0] v);
        return {{16{v[47]}}, v[47:0]};
    endfunction

    function automatic logic [63:0] round_px(input logic [63:0] v);
        logic [63:0] w;
        w = v + (64'd1 << (FRAC_BITS - 1));
        if (w[63]) begin
            return -((-w) >> FRAC_BITS);
        end
        return w >> FRAC_BITS;
    endfunction

    task automatic push_point(input logic [63:0] x, input logic [63:0] y,
                              input logic st, input logic last, input logic done);
        t_point p;
        p.px   = x[PT_W-1:0];
        p.py   = y[PT_W-1:0];
        p.col  = ell_color;
        p.st   = st;
        p.last = last;
        p.done = done;
        exp_points.push_back(p);
    endtask

    task automatic push_mirrors(input logic [63:0] a, input logic [63:0] b, input logic done);
        push_point(ell_cx - a, ell_cy + b, 1'b0, 1'b0, 1'b0);
        push_point(ell_cx - a, ell_cy - b, 1'b0, 1'b0, 1'b0);
        push_point(ell_cx + a, ell_cy + b, 1'b0, 1'b0, 1'b0);
        push_point(ell_cx + a, ell_cy - b, 1'b0, 1'b1, done);
    endtask

    task automatic predict_ellipse(input logic req, input logic [IN_W-1:0] d);
        logic [63:0] r1, r2, n, t, t2, term, c, s, nx, ny;
        r1 = 64'(d[2*CTR_W+RAD_W-1:2*CTR_W]);
        r2 = 64'(d[2*CTR_W+2*RAD_W-1:2*CTR_W+RAD_W]);
        if (req == epir_pkg::REQ_START) begin
            ell_active = 1'b0;
            if ((r1 >> RAD_FRAC) == 0 || (r2 >> RAD_FRAC) == 0) begin
                push_point(64'd0, 64'd0, 1'b1, 1'b1, 1'b0);
                return;
            end
            ell_cx = 64'(d[CTR_W-1:0]);
            ell_cy = 64'(d[2*CTR_W-1:CTR_W]);
            n  = ((r1 > r2) ? r1 : r2) >> RAD_FRAC;
            t  = (64'd1 << FRAC_BITS) / n;
            t2 = umul_fx(t, t);
            term = 64'd1 << FRAC_BITS;
            c = term;
            for (int k = 1; k <= epir_pkg::SERIES_TERMS; k++) begin
                term = umul_fx(term, t2) / 64'((2 * k - 1) * (2 * k));
                c = (k % 2 == 1) ? c - term : c + term;
            end
            term = t;
            s = t;
            for (int k = 1; k <= epir_pkg::SERIES_TERMS; k++) begin
                term = umul_fx(term, t2) / 64'((2 * k) * (2 * k + 1));
                s = (k % 2 == 1) ? s - term : s + term;
            end
            ell_cos = c;
            ell_sin = s;
            ell_rxy = (r1 << FRAC_BITS) / r2;
            ell_ryx = (r2 << FRAC_BITS) / r1;
            ell_px  = wrap_pos(r1 << (FRAC_BITS - RAD_FRAC));
            ell_py  = '0;
            ell_active = 1'b1;
            push_mirrors(r1 >> RAD_FRAC, 64'd0, 1'b0);
        end else if (ell_active) begin
            nx = smul_fx(ell_px, ell_cos) - smul_fx(smul_fx(ell_rxy, ell_py), ell_sin);
            ny = smul_fx(ell_py, ell_cos) + smul_fx(smul_fx(ell_ryx, ell_px), ell_sin);
            ell_px = wrap_pos(nx);
            ell_py = wrap_pos(ny);
            if (ell_px[63] || ell_px == 0) begin
                ell_active = 1'b0;
            end
            push_mirrors(round_px(ell_px), round_px(ell_py), !ell_active);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic send_word(input logic req, input logic [11:0] cx, input logic [11:0] cy,
                             input logic [19:0] rx, input logic [19:0] ry);
        if (i_clk) @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 37) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = {$urandom, $urandom};
            s_axis_tuser  = $urandom_range(1);
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = {ry, rx, cy, cx};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_ellipse(req, {ry, rx, cy, cx});
        words_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic step_word();
        send_word(epir_pkg::REQ_STEP, 12'($urandom), 12'($urandom), 20'($urandom),
                  20'($urandom));
    endtask

    task automatic wait_drained();
        while (exp_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_color(input logic [COL_W-1:0] col);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = col;
        ell_color   = col;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 24'($urandom);
    endtask

    // start then step until the ellipse closes or the step guard runs out
    task automatic draw_whole(input logic [11:0] cx, input logic [11:0] cy,
                              input logic [19:0] rx, input logic [19:0] ry);
        int guard;
        guard = 0;
        send_word(epir_pkg::REQ_START, cx, cy, rx, ry);
        while (ell_active && guard < 400) begin
            step_word();
            guard++;
        end
    endtask

    task automatic test_default_color();
        draw_whole(12'd100, 12'd200, 20'h00300, 20'h00200);
    endtask

    task automatic test_directed();
        step_word();
        send_word(epir_pkg::REQ_START, 12'd0, 12'd0, 20'h000FF, 20'h00500);
        send_word(epir_pkg::REQ_START, 12'd4095, 12'd4095, 20'hFFFFF, 20'h00080);
        send_word(epir_pkg::REQ_START, 12'd7, 12'd9, 20'h00000, 20'h00000);
        step_word();
        send_word(epir_pkg::REQ_START, 12'd4095, 12'd0, 20'hFFFFF, 20'hFFFFF);
        step_word();
        step_word();
        send_word(epir_pkg::REQ_START, 12'd0, 12'd4095, 20'h00100, 20'hFFFFF);
        step_word();
        draw_whole(12'd4095, 12'd4095, 20'h00100, 20'h00100);
        draw_whole(12'd0, 12'd0, 20'h014FF, 20'h00180);
    endtask

    task automatic test_color_register();
        write_color(24'h000000);
        draw_whole(12'd2048, 12'd1, 20'h00280, 20'h00640);
        write_color(24'hFFFFFF);
        send_word(epir_pkg::REQ_START, 12'd5, 12'd5, 20'h00050, 20'h00300);
        draw_whole(12'd1, 12'd2048, 20'h00500, 20'h002C0);
        write_color(24'($urandom));
    endtask

    task automatic test_random(input int target);
        int pick, guard, cut;
        logic [19:0] rx, ry;
        while (words_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                write_color(24'($urandom));
            end
            no_idle = (pick >= 40 && pick < 50);
            if (pick < 12) begin
                rx = 20'($urandom);
                ry = 20'($urandom);
                if ($urandom_range(1)) rx[19:8] = '0; else ry[19:8] = '0;
                send_word(epir_pkg::REQ_START, 12'($urandom), 12'($urandom), rx, ry);
                step_word();
            end else if (pick < 20) begin
                send_word(epir_pkg::REQ_START, 12'($urandom), 12'($urandom), 20'($urandom),
                          20'($urandom));
                repeat ($urandom_range(1, 4)) step_word();
            end else begin
                rx = {12'($urandom_range(1, 18)), 8'($urandom)};
                ry = {12'($urandom_range(1, 18)), 8'($urandom)};
                send_word(epir_pkg::REQ_START, 12'($urandom), 12'($urandom), rx, ry);
                cut = (pick < 30) ? $urandom_range(1, 8) : 400;
                guard = 0;
                while (ell_active && guard < cut) begin
                    step_word();
                    guard++;
                end
                if (pick % 5 == 0) step_word();
            end
        end
        no_idle = 1'b0;
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 37);
    end

    always @(posedge i_clk) begin
        t_point p;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (exp_points.size() == 0) begin
                report_mismatch("unexpected word", 32'(m_axis_tdata), 32'd0);
            end else begin
                p = exp_points.pop_front();
                if (m_axis_tdata[PT_W-1:0] !== p.px)
                    report_mismatch("point_x", 32'(m_axis_tdata[PT_W-1:0]), 32'(p.px));
                if (m_axis_tdata[2*PT_W-1:PT_W] !== p.py)
                    report_mismatch("point_y", 32'(m_axis_tdata[2*PT_W-1:PT_W]), 32'(p.py));
                if (m_axis_tdata[2*PT_W+COL_W-1:2*PT_W] !== p.col)
                    report_mismatch("pixel_color", 32'(m_axis_tdata[2*PT_W+COL_W-1:2*PT_W]),
                                    32'(p.col));
                if (m_axis_tuser[0] !== p.st)
                    report_mismatch("status", 32'(m_axis_tuser[0]), 32'(p.st));
                if (m_axis_tuser[1] !== p.done)
                    report_mismatch("ellipse_done", 32'(m_axis_tuser[1]), 32'(p.done));
                if (m_axis_tlast !== p.last)
                    report_mismatch("last_of_step", 32'(m_axis_tlast), 32'(p.last));
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        err_count    = 0;
        words_sent   = 0;
        no_idle      = 1'b0;
        quiet_cycles = 0;
        ell_px = '0; ell_py = '0; ell_cos = '0; ell_sin = '0;
        ell_rxy = '0; ell_ryx = '0; ell_cx = '0; ell_cy = '0;
        ell_active = 1'b0;
        ell_color  = epir_pkg::COLOR_RESET;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_default_color();
        test_directed();
        test_color_register();
        test_random(370);
        wait_drained();
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
rtl/epir_pkg.sv
rtl/epir_alu.sv
rtl/ellipse_polar_iterative_raster_unit.sv
rtl/epir_checker.sv
verif/tb_top.sv
